// ===== rtl/rpdma_pkg.sv =====
// Shared types and constants for the register-programmed DMA copier.
package rpdma_pkg;

    localparam int ADDR_BITS_DEF = 32;

    // Input command codes.
    typedef enum logic [1:0] {
        CMD_REG_READ  = 2'd0,
        CMD_REG_WRITE = 2'd1,
        CMD_MEM_DATA  = 2'd2,
        CMD_NOP       = 2'd3
    } cmd_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_RDATA  = 2'd0,
        KIND_MREAD  = 2'd1,
        KIND_MWRITE = 2'd2,
        KIND_ACK    = 2'd3
    } kind_t;

    // Byte offsets of the CPU registers, for writes.
    localparam logic [7:0] OFF_SOURCE = 8'd0;
    localparam logic [7:0] OFF_TARGET = 8'd4;
    localparam logic [7:0] OFF_SIZE   = 8'd8;
    localparam logic [7:0] OFF_START  = 8'd12;

    // Word indexes of the CPU registers, for reads.
    localparam logic [5:0] REG_SOURCE = 6'd0;
    localparam logic [5:0] REG_TARGET = 6'd1;
    localparam logic [5:0] REG_SIZE   = 6'd2;
    localparam logic [5:0] REG_START  = 6'd3;

    localparam logic [31:0] START_GO = 32'd1;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] addr;
        logic [31:0] data;
        logic        irq;
        logic        last;
    } result_t;

endpackage

// ===== rtl/register_programmed_dma_copier.sv =====
// Path: an accepted item waits in the input register, which feeds the result register through
// the core logic. Throughput: one item per cycle while each item gives one result and the output
// is not stalled; an item that gives two results holds the result register until both have left,
// and the input register takes one more item before the input side stalls.
// Reset: synchronous active-low aresetn clears the valid flags, the CPU registers, the run state
// and the interrupt; the data registers are not cleared, and no result is pending after reset.
module register_programmed_dma_copier #(
    parameter int ADDR_BITS = rpdma_pkg::ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // reg_offset[7:0], word_value[39:8]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // bus_address[31:0], bus_data[63:32], irq_level[64], zeros
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);

    logic               in_valid_reg;
    logic [1:0]         cmd_reg;
    logic [7:0]         offset_reg;
    logic [31:0]        value_reg;
    logic               fire;
    logic               can_load;
    logic               two_results;
    rpdma_pkg::result_t res0;
    rpdma_pkg::result_t res1;
    rpdma_pkg::result_t m_result;

    assign fire     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cmd_reg    <= s_tuser;
            offset_reg <= s_tdata[7:0];
            value_reg  <= s_tdata[39:8];
        end
    end

    rpdma_core #(
        .ADDR_BITS(ADDR_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .cmd         (cmd_reg),
        .reg_offset  (offset_reg),
        .word_value  (value_reg),
        .res0        (res0),
        .res1        (res1),
        .two_results (two_results)
    );

    rpdma_outbuf u_outbuf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (fire),
        .res0        (res0),
        .res1        (res1),
        .two_results (two_results),
        .can_load    (can_load),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_result    (m_result)
    );

    assign m_tdata = {7'd0, m_result.irq, m_result.data, m_result.addr};
    assign m_tuser = m_result.kind;
    assign m_tlast = m_result.last;

endmodule

// ===== rtl/rpdma_core.sv =====
// Register file, run state and per-item result logic of the DMA copier.
module rpdma_core #(
    parameter int ADDR_BITS = rpdma_pkg::ADDR_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic [1:0]          cmd,
    input  logic [7:0]          reg_offset,
    input  logic [31:0]         word_value,
    output rpdma_pkg::result_t  res0,
    output rpdma_pkg::result_t  res1,
    output logic                two_results
);

    localparam int SUM_W = (ADDR_BITS > 32) ? ADDR_BITS : 32;

    logic [31:0]          src_reg, src_next;
    logic [31:0]          dst_reg, dst_next;
    logic [31:0]          size_reg, size_next;
    logic [31:0]          start_reg, start_next;
    logic [29:0]          idx_reg, idx_next;
    logic [29:0]          total_reg, total_next;
    logic                 busy_reg, busy_next;
    logic                 irq_reg, irq_next;
    logic [ADDR_BITS-1:0] run_src_reg, run_src_next;
    logic [ADDR_BITS-1:0] run_dst_reg, run_dst_next;

    // Address of word idx of a run, wrapped to the address width.
    function automatic logic [31:0] word_addr(input logic [ADDR_BITS-1:0] base,
                                              input logic [29:0] idx);
        logic [SUM_W-1:0]     sum;
        logic [ADDR_BITS-1:0] wrapped;
        sum     = SUM_W'(base) + SUM_W'({idx, 2'b00});
        wrapped = sum[ADDR_BITS-1:0];
        return 32'(wrapped);
    endfunction

    always_comb begin
        src_next     = src_reg;
        dst_next     = dst_reg;
        size_next    = size_reg;
        start_next   = start_reg;
        idx_next     = idx_reg;
        total_next   = total_reg;
        busy_next    = busy_reg;
        irq_next     = irq_reg;
        run_src_next = run_src_reg;
        run_dst_next = run_dst_reg;
        res0         = '{kind: rpdma_pkg::KIND_ACK, addr: 32'd0, data: 32'd0,
                         irq: 1'b0, last: 1'b1};
        res1         = res0;
        two_results  = 1'b0;

        if (fire) begin
            case (rpdma_pkg::cmd_t'(cmd))
                rpdma_pkg::CMD_REG_READ: begin
                    res0.kind = rpdma_pkg::KIND_RDATA;
                    case (reg_offset[7:2])
                        rpdma_pkg::REG_SOURCE: res0.data = src_reg;
                        rpdma_pkg::REG_TARGET: res0.data = dst_reg;
                        rpdma_pkg::REG_SIZE:   res0.data = size_reg;
                        rpdma_pkg::REG_START:  res0.data = start_reg;
                        default:               res0.data = 32'd0;
                    endcase
                end
                rpdma_pkg::CMD_REG_WRITE: begin
                    if (reg_offset == rpdma_pkg::OFF_SOURCE && start_reg == 32'd0) begin
                        src_next = word_value;
                    end else if (reg_offset == rpdma_pkg::OFF_TARGET
                                 && start_reg == 32'd0) begin
                        dst_next = word_value;
                    end else if (reg_offset == rpdma_pkg::OFF_SIZE
                                 && start_reg == 32'd0) begin
                        size_next = word_value;
                    end else if (reg_offset == rpdma_pkg::OFF_START) begin
                        start_next = word_value;
                    end

                    if (start_next != rpdma_pkg::START_GO) begin
                        irq_next = 1'b0;
                    end else if (!busy_reg && !irq_reg) begin
                        // A negative size copies nothing.
                        total_next   = size_next[31] ? 30'd0 : size_next[31:2];
                        idx_next     = 30'd0;
                        run_src_next = ADDR_BITS'(src_next);
                        run_dst_next = ADDR_BITS'(dst_next);
                        if (total_next == 30'd0) begin
                            irq_next = 1'b1;
                        end else begin
                            busy_next   = 1'b1;
                            two_results = 1'b1;
                            res1.kind   = rpdma_pkg::KIND_MREAD;
                            res1.addr   = word_addr(run_src_next, 30'd0);
                        end
                    end
                end
                rpdma_pkg::CMD_MEM_DATA: begin
                    if (busy_reg) begin
                        res0.kind = rpdma_pkg::KIND_MWRITE;
                        res0.addr = word_addr(run_dst_reg, idx_reg);
                        res0.data = word_value;
                        idx_next  = idx_reg + 30'd1;
                        if (idx_next >= total_reg) begin
                            busy_next = 1'b0;
                            irq_next  = (start_reg == rpdma_pkg::START_GO);
                        end else begin
                            two_results = 1'b1;
                            res1.kind   = rpdma_pkg::KIND_MREAD;
                            res1.addr   = word_addr(run_src_reg, idx_next);
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // Every result of one item carries the interrupt level left by that item.
        res0.irq  = irq_next;
        res1.irq  = irq_next;
        res0.last = !two_results;
        res1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg     <= 32'd0;
            dst_reg     <= 32'd0;
            size_reg    <= 32'd0;
            start_reg   <= 32'd0;
            idx_reg     <= 30'd0;
            total_reg   <= 30'd0;
            busy_reg    <= 1'b0;
            irq_reg     <= 1'b0;
            run_src_reg <= '0;
            run_dst_reg <= '0;
        end else begin
            src_reg     <= src_next;
            dst_reg     <= dst_next;
            size_reg    <= size_next;
            start_reg   <= start_next;
            idx_reg     <= idx_next;
            total_reg   <= total_next;
            busy_reg    <= busy_next;
            irq_reg     <= irq_next;
            run_src_reg <= run_src_next;
            run_dst_reg <= run_dst_next;
        end
    end

endmodule

// ===== rtl/rpdma_outbuf.sv =====
// Result register with a second slot for items that produce two results.
module rpdma_outbuf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  rpdma_pkg::result_t res0,
    input  rpdma_pkg::result_t res1,
    input  logic               two_results,
    output logic               can_load,
    output logic               m_tvalid,
    input  logic               m_tready,
    output rpdma_pkg::result_t m_result
);

    logic               out_valid_reg;
    logic               pend_valid_reg;
    rpdma_pkg::result_t out_reg;
    rpdma_pkg::result_t pend_reg;

    // New results may enter once the current one leaves and nothing waits behind it.
    assign can_load = !out_valid_reg || (m_tready && !pend_valid_reg);
    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg  <= 1'b1;
            pend_valid_reg <= two_results;
        end else if (out_valid_reg && m_tready) begin
            out_valid_reg  <= pend_valid_reg;
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg  <= res0;
            pend_reg <= res1;
        end else if (out_valid_reg && m_tready && pend_valid_reg) begin
            out_reg <= pend_reg;
        end
    end

endmodule
